[rtl/core/assert_macros.svh]
// assert_macros.svh - shared assertion macros for the task scheduler checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg
// Types and codes shared by the priority task scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam int PRIO_W = 16;
  localparam int TASK_W = 16;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  localparam logic MODE_REGISTER = 1'b0;
  localparam logic MODE_EXECUTE  = 1'b1;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DISPATCH = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [TASK_W-1:0]        task_id;
  } pst_entry_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } pst_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/priority_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// priority_task_scheduler_top
// Stable priority task table with ordered dispatch.
// ----------------------------------------------------------------------------
// Input beats carry mode, priority_req and task_id under in_valid/in_ready.
// Result beats carry status, out_task_id, out_priority and last under
// out_valid/out_ready. Capacity is set through the APB port at address 0.
// A register beat, if there is room, is sorted into the cell row as it is
// accepted; its single result appears on the next cycle. An execute beat on
// an empty table yields one EMPTY result; else the row rotates one cell per
// cycle while the output register is free, registering the head cell as a
// result each step. Input is taken one beat at a time, only while no execute
// is in progress and the output register is free or being drained.
// Reset empties the table and sets capacity to 16. When the receiver stalls,
// the held result stays put and dispatch pauses with the row intact.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler_top #(
  parameter int MAX_TASKS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic signed [pst_pkg::PRIO_W-1:0] priority_req,
  input  logic [pst_pkg::TASK_W-1:0]        task_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [pst_pkg::TASK_W-1:0]        out_task_id,
  output logic signed [pst_pkg::PRIO_W-1:0] out_priority,
  output logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import pst_pkg::*;

  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic             state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    remaining, remaining_next;
  logic [CAP_W-1:0] capacity;

  logic                     out_valid_next;
  logic [1:0]               status_next;
  logic [TASK_W-1:0]        out_task_id_next;
  logic signed [PRIO_W-1:0] out_priority_next;
  logic                     last_next;

  logic       out_free;
  logic       in_acc;
  logic       room;
  pst_ctrl_t  ctrl;
  pst_entry_t head;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2:2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign room     = (CMPW'(count) < CMPW'(capacity)) && (count < CW'(MAX_TASKS));

  assign ctrl.insert = in_acc && (mode == MODE_REGISTER) && room;
  assign ctrl.rotate = (state == S_EXEC) && out_free;

  pst_chain #(
    .MAX_TASKS (MAX_TASKS)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .new_prio (priority_req),
    .new_task (task_id),
    .count    (count),
    .head     (head)
  );

  always_comb begin
    state_next        = state;
    count_next        = count;
    remaining_next    = remaining;
    out_valid_next    = out_valid && !out_ready;
    status_next       = status;
    out_task_id_next  = out_task_id;
    out_priority_next = out_priority;
    last_next         = last;

    if (in_acc) begin
      if (mode == MODE_REGISTER) begin
        out_valid_next    = 1'b1;
        status_next       = room ? ST_ACCEPTED : ST_FULL;
        out_task_id_next  = '0;
        out_priority_next = '0;
        last_next         = 1'b1;
        if (room) begin
          count_next = count + CW'(1);
        end
      end else if (count == '0) begin
        out_valid_next    = 1'b1;
        status_next       = ST_EMPTY;
        out_task_id_next  = '0;
        out_priority_next = '0;
        last_next         = 1'b1;
      end else begin
        state_next     = S_EXEC;
        remaining_next = count;
      end
    end

    if (ctrl.rotate) begin
      out_valid_next    = 1'b1;
      status_next       = ST_DISPATCH;
      out_task_id_next  = head.task_id;
      out_priority_next = head.prio;
      last_next         = (remaining == CW'(1));
      remaining_next    = remaining - CW'(1);
      if (remaining == CW'(1)) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    status       <= status_next;
    out_task_id  <= out_task_id_next;
    out_priority <= out_priority_next;
    last         <= last_next;
  end

endmodule

`default_nettype wire

[rtl/core/pst_cell.sv]
// ----------------------------------------------------------------------------
// pst_cell
// One slot of the sorted task row: keeps, takes the new task, or takes a
// neighbor's entry or, at the tail during rotation, the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  pst_pkg::pst_ctrl_t                ctrl,
  input  logic signed [pst_pkg::PRIO_W-1:0] new_prio,
  input  logic [pst_pkg::TASK_W-1:0]        new_task,
  input  pst_pkg::pst_entry_t               prev,
  input  pst_pkg::pst_entry_t               next,
  input  pst_pkg::pst_entry_t               head,
  input  logic                              prev_ge,
  input  logic                              is_tail,
  output pst_pkg::pst_entry_t               ent,
  output logic                              ge
);
  import pst_pkg::*;

  pst_entry_t ent_next;

  // entry stays ahead of the new task on ties, which keeps insertion order
  assign ge = ent.valid && ($signed(ent.prio) >= $signed(new_prio));

  always_comb begin
    ent_next = ent;
    if (ctrl.insert) begin
      if (!ge) begin
        if (prev_ge) begin
          ent_next.valid   = 1'b1;
          ent_next.prio    = new_prio;
          ent_next.task_id = new_task;
        end else begin
          ent_next = prev;
        end
      end
    end else if (ctrl.rotate) begin
      ent_next = is_tail ? head : next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pst_chain.sv]
// ----------------------------------------------------------------------------
// pst_chain
// Row of task cells held in descending priority order; rotates on dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_chain #(
  parameter int MAX_TASKS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pst_pkg::pst_ctrl_t                  ctrl,
  input  logic signed [pst_pkg::PRIO_W-1:0]   new_prio,
  input  logic [pst_pkg::TASK_W-1:0]          new_task,
  input  logic [$clog2(MAX_TASKS+1)-1:0]      count,
  output pst_pkg::pst_entry_t                 head
);
  import pst_pkg::*;

  localparam int CW = $clog2(MAX_TASKS + 1);

  pst_entry_t ents [MAX_TASKS];
  logic       ges  [MAX_TASKS];

  assign head = ents[0];

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    pst_entry_t prev_ent;
    pst_entry_t next_ent;
    logic       prev_ge;
    logic       is_tail;

    if (i == 0) begin : g_first
      assign prev_ent = '0;
      assign prev_ge  = 1'b1;
    end else begin : g_mid
      assign prev_ent = ents[i-1];
      assign prev_ge  = ges[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_end
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ents[i+1];
    end

    assign is_tail = (count == CW'(i + 1));

    pst_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .new_prio (new_prio),
      .new_task (new_task),
      .prev     (prev_ent),
      .next     (next_ent),
      .head     (ents[0]),
      .prev_ge  (prev_ge),
      .is_tail  (is_tail),
      .ent      (ents[i]),
      .ge       (ges[i])
    );
  end

endmodule

`default_nettype wire

[rtl/core/pst_checker.sv]
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks for the priority task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        mode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [15:0] out_task_id,
  input wire logic [15:0] out_priority,
  input wire logic        last
);
  import pst_pkg::*;

  logic reg_beat;
  logic non_dispatch;
  logic out_stall;
  logic reg_status;

  assign reg_beat     = in_valid && in_ready && (mode == MODE_REGISTER);
  assign non_dispatch = out_valid && (status != ST_DISPATCH);
  assign out_stall    = out_valid && !out_ready;
  assign reg_status   = (status == ST_ACCEPTED) || (status == ST_FULL);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable({status, out_task_id, last}))
  `ASSERT_NEXT(a_reg_result, clk, rst, reg_beat, out_valid && last && reg_status)
  `ASSERT_IMPLY(a_single_last, clk, rst, non_dispatch, last)
  `ASSERT_IMPLY(a_zero_fields, clk, rst, non_dispatch, (out_task_id == '0) && (out_priority == '0))

endmodule

bind priority_task_scheduler_top pst_checker u_pst_checker (.*);

`default_nettype wire

[tb/tb_priority_task_scheduler_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler_top
// Self-checking bench for the priority task scheduler.
// ----------------------------------------------------------------------------
// Register and execute beats go in under random gaps while the result side
// stalls at random. A scoreboard keeps its own copy of the task table and the
// capacity, works out the result beats of every accepted input beat, and
// compares each result beat field by field. Capacity is written over the APB
// port between phases, covering zero, one, the table size and values past it,
// and lowering it under the stored count.
// ----------------------------------------------------------------------------

module tb_priority_task_scheduler_top;
  import pst_pkg::*;

  localparam int TASK_SLOTS = 16;
  localparam int END_SLACK  = TASK_SLOTS + 4;

  typedef struct packed {
    logic [1:0]               status;
    logic [TASK_W-1:0]        task_id;
    logic signed [PRIO_W-1:0] prio;
    logic                     last;
  } sched_result_t;

  class task_order_board;
    logic signed [PRIO_W-1:0] prio_tab[TASK_SLOTS];
    logic [TASK_W-1:0]        task_tab[TASK_SLOTS];
    int                       stored;
    logic [CAP_W-1:0]         cap;
    sched_result_t            due[$];
    int                       errors;
    int                       n_register;
    int                       n_execute;
    int                       n_results;

    function new();
      stored = 0;
      cap = CAP_RESET;
      errors = 0;
      n_register = 0;
      n_execute = 0;
      n_results = 0;
    endfunction

    function void push_due(logic [1:0] st, logic [TASK_W-1:0] tid,
                           logic signed [PRIO_W-1:0] pr, logic lst);
      sched_result_t r;
      r.status = st;
      r.task_id = tid;
      r.prio = pr;
      r.last = lst;
      due.push_back(r);
    endfunction

    function void note_item(logic m, logic signed [PRIO_W-1:0] pr,
                            logic [TASK_W-1:0] tid);
      int lim;
      int ord[TASK_SLOTS];
      int j;
      lim = (cap < TASK_SLOTS) ? int'(cap) : TASK_SLOTS;
      if (m == MODE_REGISTER) begin
        n_register++;
        if (stored < lim) begin
          prio_tab[stored] = pr;
          task_tab[stored] = tid;
          stored++;
          push_due(ST_ACCEPTED, '0, '0, 1'b1);
        end else begin
          push_due(ST_FULL, '0, '0, 1'b1);
        end
      end else begin
        n_execute++;
        if (stored == 0) begin
          push_due(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          // stable insertion sort, highest priority first
          for (int i = 0; i < stored; i++) begin
            j = i;
            while (j > 0 && prio_tab[ord[j-1]] < prio_tab[i]) begin
              ord[j] = ord[j-1];
              j--;
            end
            ord[j] = i;
          end
          for (int i = 0; i < stored; i++)
            push_due(ST_DISPATCH, task_tab[ord[i]], prio_tab[ord[i]],
                     (i == stored - 1));
        end
      end
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp;
      n_results++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result beat %0d with none expected", $realtime, n_results);
          $display("  got status %0d task %h prio %0d last %0d",
                   got.status, got.task_id, got.prio, got.last);
        end
        return;
      end
      exp = due.pop_front();
      if (got.status !== exp.status || got.task_id !== exp.task_id ||
          got.prio !== exp.prio || got.last !== exp.last) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result beat %0d mismatch", $realtime, n_results);
          $display("  exp status %0d task %h prio %0d last %0d",
                   exp.status, exp.task_id, exp.prio, exp.last);
          $display("  got status %0d task %h prio %0d last %0d",
                   got.status, got.task_id, got.prio, got.last);
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     mode;
  logic signed [PRIO_W-1:0] priority_req;
  logic [TASK_W-1:0]        task_id;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status;
  logic [TASK_W-1:0]        out_task_id;
  logic signed [PRIO_W-1:0] out_priority;
  logic                     last;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [2:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  task_order_board board;
  int tx_quiet;
  int rx_quiet;
  int hold_cycles;
  int cap_settings;

  priority_task_scheduler_top #(.MAX_TASKS(TASK_SLOTS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .priority_req(priority_req), .task_id(task_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_task_id(out_task_id), .out_priority(out_priority),
    .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // random idle gap, with occasional runs of back-to-back beats
  function automatic int pick_gap(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0)
      quiet = $urandom_range(5, 20);
    return $urandom_range(0, 16);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(input logic m, input logic signed [PRIO_W-1:0] pr,
                           input logic [TASK_W-1:0] tid);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    priority_req <= pr;
    task_id <= tid;
    do @(posedge clk); while (!in_ready);
    board.note_item(m, pr, tid);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic                     m;
    logic signed [PRIO_W-1:0] pr;
    m = ($urandom_range(0, 3) == 0) ? MODE_EXECUTE : MODE_REGISTER;
    case ($urandom_range(0, 3))
      0: pr = 16'($urandom_range(0, 4) - 2);
      1: pr = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: pr = 16'($urandom);
    endcase
    send_beat(m, pr, 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.due.size() != 0);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(REG_CAPACITY) << 2;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.cap = value;
    cap_settings++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // result side
  initial begin
    sched_result_t got;
    int wait_n;
    out_ready = 1'b0;
    rx_quiet = 0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      wait_n = pick_gap(rx_quiet) + hold_cycles;
      hold_cycles = 0;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.status = status;
      got.task_id = out_task_id;
      got.prio = out_priority;
      got.last = last;
      board.check_result(got);
      @(negedge clk);
    end
  end

  initial begin
    logic [CAP_W-1:0] phase_cap[6];
    board = new();
    tx_quiet = 0;
    hold_cycles = 0;
    cap_settings = 0;
    phase_cap = '{5'd3, 5'd7, 5'd12, 5'd16, 5'd31, 5'd2};
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_REGISTER;
    priority_req = '0;
    task_id = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table at reset capacity
    send_beat(MODE_EXECUTE, 16'sh7FFF, 16'hFFFF);
    // zero capacity refuses every register beat
    write_capacity(5'd0);
    send_beat(MODE_REGISTER, 16'sh7FFF, 16'hFFFF);
    send_beat(MODE_EXECUTE, 16'sh8000, 16'h0000);
    // single slot
    write_capacity(5'd1);
    send_beat(MODE_REGISTER, 16'sh8000, 16'h0000);
    send_beat(MODE_REGISTER, 16'sh0001, 16'h1234);
    send_beat(MODE_EXECUTE, 16'($urandom), 16'($urandom));
    // ties keep insertion order; extremes of both fields
    write_capacity(5'd5);
    send_beat(MODE_REGISTER, 16'sh7FFF, 16'hFFFF);
    send_beat(MODE_REGISTER, 16'sd5, 16'hAAAA);
    send_beat(MODE_REGISTER, 16'sd5, 16'h5555);
    send_beat(MODE_REGISTER, -16'sd1, 16'h0F0F);
    send_beat(MODE_REGISTER, 16'sd5, 16'hF0F0);
    send_beat(MODE_EXECUTE, 16'($urandom), 16'($urandom));
    send_beat(MODE_EXECUTE, 16'($urandom), 16'($urandom));

    // random phases; the first lowers capacity below the stored count
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(phase_cap[ph]);
      for (int k = 0; k < 28; k++) begin
        if (ph == 2 && k == 8)
          hold_cycles = 300;
        if (ph == 3 && k == 15)
          drain();
        send_random();
      end
    end

    drain();
    repeat (END_SLACK) @(posedge clk);
    if (board.due.size() != 0) begin
      board.errors++;
      $display("%0d result beats never arrived", board.due.size());
    end
    $display("Covered %0d register and %0d execute beats, %0d result beats checked,",
             board.n_register, board.n_execute, board.n_results);
    $display("over %0d capacity writes with up to %0d stored tasks.",
             cap_settings, board.stored);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
